// ===== hdl/page_map_ftl_with_gc_assert.svh =====
// assertion macros for the port-level checker file
`ifndef PAGE_MAP_FTL_WITH_GC_ASSERT_SVH
`define PAGE_MAP_FTL_WITH_GC_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PMFTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PMFTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pmftl_pkg.sv =====
// shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package pmftl_pkg;

  localparam int DATA_BLOCKS    = 16;
  localparam int PAGES_IN_BLOCK = 4;
  localparam int LOGICAL_PAGES  = 64;
  localparam int PHYS_PAGES     = DATA_BLOCKS * PAGES_IN_BLOCK;

  localparam int PAGE_W   = $clog2(PHYS_PAGES);
  localparam int BLK_W    = $clog2(DATA_BLOCKS);
  localparam int OFF_W    = $clog2(PAGES_IN_BLOCK);
  localparam int CNT_W    = $clog2(PAGES_IN_BLOCK + 1);
  localparam int LSN_W    = 6;
  localparam int FPAGE_W  = 7;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAP   = 2'd0,
    KIND_COPY  = 2'd1,
    KIND_ERASE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_UNMAPPED = 2'd1,
    STAT_NO_PAGE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    EMIT_MAP,
    EMIT_COPY_OUT,
    EMIT_ERASE_VIC,
    EMIT_COPY_BACK,
    EMIT_ERASE_SPARE
  } emit_t;

  typedef struct packed {
    logic  capture;
    logic  read_result;
    logic  mark_old;
    logic  scan_clear;
    logic  scan_step;
    logic  free_take;
    logic  victim_take;
    logic  set_fail;
    logic  off_step;
    logic  emit;
    emit_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic read_op;
    logic free_hit;
    logic scan_last;
    logic vic_full;
    logic pick_nz;
    logic live_bit;
    logic off_last;
    logic slot_free;
  } dp_stat_t;

endpackage

// ===== hdl/pmftl_dp.sv =====
// datapath: map table, page bitmaps, block scan, result register
`timescale 1ns / 1ps

module pmftl_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_op,
  input  logic [pmftl_pkg::LSN_W-1:0]     in_lsn,
  input  pmftl_pkg::dp_cmd_t              cmd,
  output pmftl_pkg::dp_stat_t             stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pmftl_pkg::kind_t                out_kind,
  output logic [pmftl_pkg::FPAGE_W-1:0]   out_first,
  output logic [pmftl_pkg::FPAGE_W-1:0]   out_second,
  output pmftl_pkg::status_t              out_status,
  output logic                            out_last
);

  localparam int PIB = pmftl_pkg::PAGES_IN_BLOCK;
  localparam int PW  = pmftl_pkg::PAGE_W;
  localparam int FW  = pmftl_pkg::FPAGE_W;
  localparam int CW  = pmftl_pkg::CNT_W;
  localparam int OW  = pmftl_pkg::OFF_W;
  localparam int BW  = pmftl_pkg::BLK_W;

  function automatic logic [CW-1:0] count_ones(input logic [PIB-1:0] v);
    logic [CW-1:0] c;
    c = '0;
    for (int i = 0; i < PIB; i++) c = c + CW'(v[i]);
    return c;
  endfunction

  function automatic logic [OW-1:0] first_one(input logic [PIB-1:0] v);
    logic [OW-1:0] f;
    f = '0;
    for (int i = PIB - 1; i >= 0; i--) if (v[i]) f = OW'(i);
    return f;
  endfunction

  logic [PW-1:0]  map_mem [pmftl_pkg::LOGICAL_PAGES];
  logic [pmftl_pkg::LOGICAL_PAGES-1:0] map_vld;
  logic [pmftl_pkg::PHYS_PAGES-1:0]    garbage;
  logic [pmftl_pkg::PHYS_PAGES-1:0]    written;

  pmftl_pkg::op_t     op_r;
  pmftl_pkg::status_t res_status;
  logic [pmftl_pkg::LSN_W-1:0] lsn_r;
  logic [PW-1:0]  map_rd;
  logic           map_hit;
  logic [PW-1:0]  res_page;
  logic [BW-1:0]  blk;
  logic [BW-1:0]  best_blk;
  logic [CW-1:0]  best_cnt;
  logic [BW-1:0]  victim;
  logic [PIB-1:0] live;
  logic [OW-1:0]  off;

  logic [PIB-1:0] wr_slice;
  logic [PIB-1:0] gb_slice;
  logic [CW-1:0]  cur_cnt;
  logic [BW-1:0]  pick_blk;
  logic [CW-1:0]  pick_cnt;
  logic [PIB-1:0] pick_slice;
  logic [PW-1:0]  vbase;
  logic [PW-1:0]  blk_base;
  logic           commit_map;

  assign wr_slice   = written[blk * PIB +: PIB];
  assign gb_slice   = garbage[blk * PIB +: PIB];
  assign cur_cnt    = count_ones(gb_slice);
  // greedy choice: more garbage wins, lower block on ties
  assign pick_blk   = ((blk == '0) || (cur_cnt > best_cnt)) ? blk : best_blk;
  assign pick_cnt   = ((blk == '0) || (cur_cnt > best_cnt)) ? cur_cnt : best_cnt;
  assign pick_slice = garbage[pick_blk * PIB +: PIB];
  assign vbase      = PW'(PW'(victim) * PW'(PIB));
  assign blk_base   = PW'(PW'(blk) * PW'(PIB));
  assign commit_map = cmd.emit && (cmd.emit_sel == pmftl_pkg::EMIT_MAP) &&
                      (op_r == pmftl_pkg::OP_WRITE);

  assign stat.read_op   = (op_r == pmftl_pkg::OP_READ);
  assign stat.free_hit  = ~(&wr_slice);
  assign stat.scan_last = (blk == BW'(pmftl_pkg::DATA_BLOCKS - 1));
  assign stat.vic_full  = (cur_cnt == CW'(PIB));
  assign stat.pick_nz   = (pick_cnt != '0);
  assign stat.live_bit  = live[off];
  assign stat.off_last  = (off == OW'(PIB - 1));
  assign stat.slot_free = !out_valid || out_ready;

  // map table memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      map_rd <= map_mem[in_lsn];
    end
    if (commit_map && (res_status == pmftl_pkg::STAT_OK)) begin
      map_mem[lsn_r] <= res_page;
    end
  end

  // control state: valid bits, bitmaps, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld   <= '0;
      garbage   <= '0;
      written   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.mark_old && map_hit) begin
        garbage[map_rd] <= 1'b1;
      end
      if (cmd.emit && (cmd.emit_sel == pmftl_pkg::EMIT_ERASE_VIC)) begin
        garbage[vbase +: PIB] <= '0;
        written[vbase +: PIB] <= live;
      end
      if (commit_map) begin
        map_vld[lsn_r] <= (res_status == pmftl_pkg::STAT_OK);
        if (res_status == pmftl_pkg::STAT_OK) begin
          written[res_page] <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= pmftl_pkg::op_t'(in_op);
      lsn_r   <= in_lsn;
      map_hit <= map_vld[in_lsn];
    end
    if (cmd.read_result) begin
      res_page   <= map_hit ? map_rd : '0;
      res_status <= map_hit ? pmftl_pkg::STAT_OK : pmftl_pkg::STAT_UNMAPPED;
    end
    if (cmd.free_take) begin
      res_page   <= PW'(blk_base + PW'(first_one(~wr_slice)));
      res_status <= pmftl_pkg::STAT_OK;
    end
    if (cmd.set_fail) begin
      res_page   <= '0;
      res_status <= pmftl_pkg::STAT_NO_PAGE;
    end
    // after collection the victim's first garbage slot is the lowest free page
    if (cmd.emit && (cmd.emit_sel == pmftl_pkg::EMIT_ERASE_SPARE)) begin
      res_page   <= PW'(vbase + PW'(first_one(~live)));
      res_status <= pmftl_pkg::STAT_OK;
    end
    if (cmd.scan_clear) begin
      blk <= '0;
    end else if (cmd.scan_step) begin
      blk      <= blk + BW'(1);
      best_blk <= pick_blk;
      best_cnt <= pick_cnt;
    end
    if (cmd.victim_take) begin
      victim <= pick_blk;
      live   <= ~pick_slice;
      off    <= '0;
    end else if (cmd.off_step) begin
      off <= stat.off_last ? '0 : off + OW'(1);
    end
    if (cmd.emit) begin
      case (cmd.emit_sel)
        pmftl_pkg::EMIT_COPY_OUT: begin
          out_kind   <= pmftl_pkg::KIND_COPY;
          out_first  <= FW'(vbase) + FW'(off);
          out_second <= FW'(pmftl_pkg::PHYS_PAGES) + FW'(off);
          out_status <= pmftl_pkg::STAT_OK;
          out_last   <= 1'b0;
        end
        pmftl_pkg::EMIT_ERASE_VIC: begin
          out_kind   <= pmftl_pkg::KIND_ERASE;
          out_first  <= FW'(victim);
          out_second <= '0;
          out_status <= pmftl_pkg::STAT_OK;
          out_last   <= 1'b0;
        end
        pmftl_pkg::EMIT_COPY_BACK: begin
          out_kind   <= pmftl_pkg::KIND_COPY;
          out_first  <= FW'(pmftl_pkg::PHYS_PAGES) + FW'(off);
          out_second <= FW'(vbase) + FW'(off);
          out_status <= pmftl_pkg::STAT_OK;
          out_last   <= 1'b0;
        end
        pmftl_pkg::EMIT_ERASE_SPARE: begin
          out_kind   <= pmftl_pkg::KIND_ERASE;
          out_first  <= FW'(pmftl_pkg::DATA_BLOCKS);
          out_second <= '0;
          out_status <= pmftl_pkg::STAT_OK;
          out_last   <= 1'b0;
        end
        default: begin
          out_kind   <= pmftl_pkg::KIND_MAP;
          out_first  <= FW'(res_page);
          out_second <= '0;
          out_status <= res_status;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hdl/pmftl_ctrl.sv =====
// controller: sequences lookup, free scan, victim scan and collection
`timescale 1ns / 1ps

module pmftl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pmftl_pkg::dp_stat_t stat,
  output pmftl_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FREE_SCAN,
    ST_VIC_SCAN,
    ST_COPY_OUT,
    ST_ERASE_VIC,
    ST_COPY_BACK,
    ST_ERASE_SPARE,
    ST_EMIT_MAP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (stat.read_op) begin
          cmd.read_result = 1'b1;
          state_next      = ST_EMIT_MAP;
        end else begin
          cmd.mark_old   = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = ST_FREE_SCAN;
        end
      end
      ST_FREE_SCAN: begin
        if (stat.free_hit) begin
          cmd.free_take = 1'b1;
          state_next    = ST_EMIT_MAP;
        end else if (stat.scan_last) begin
          cmd.scan_clear = 1'b1;
          state_next     = ST_VIC_SCAN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_VIC_SCAN: begin
        if (stat.vic_full || stat.scan_last) begin
          if (stat.pick_nz) begin
            cmd.victim_take = 1'b1;
            state_next      = ST_COPY_OUT;
          end else begin
            cmd.set_fail = 1'b1;
            state_next   = ST_EMIT_MAP;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_COPY_OUT, ST_COPY_BACK: begin
        if (!stat.live_bit || stat.slot_free) begin
          cmd.off_step = 1'b1;
          cmd.emit     = stat.live_bit;
          cmd.emit_sel = (state == ST_COPY_OUT) ? pmftl_pkg::EMIT_COPY_OUT
                                                : pmftl_pkg::EMIT_COPY_BACK;
          if (stat.off_last) begin
            state_next = (state == ST_COPY_OUT) ? ST_ERASE_VIC : ST_ERASE_SPARE;
          end
        end
      end
      ST_ERASE_VIC: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = pmftl_pkg::EMIT_ERASE_VIC;
          state_next   = ST_COPY_BACK;
        end
      end
      ST_ERASE_SPARE: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = pmftl_pkg::EMIT_ERASE_SPARE;
          state_next   = ST_EMIT_MAP;
        end
      end
      ST_EMIT_MAP: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = pmftl_pkg::EMIT_MAP;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/page_map_ftl_with_gc.sv =====
// top level of the page-mapped flash translation engine with greedy collection
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+--------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tuser opcode, tdata logical sector
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tuser kind, tdata pages + status, tlast
//
// a read steps through accept, map table read and result register load
// a write with a free page adds a scan of the written bitmap, one block per cycle,
//   up to the block holding the page
// a write that collects adds a victim scan of up to 16 blocks and a sequence of
//   copy/erase items: copy out, erase victim, copy back, erase spare
// rst is synchronous and clears map valid bits, both bitmaps, output valid and the fsm
// one item in flight; m_axis stalls hold the fsm, s_axis_tready is high only in idle
`timescale 1ns / 1ps

module page_map_ftl_with_gc (
  input  logic                                 clk,
  input  logic                                 rst,
  // input item
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pmftl_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [5:0] logical_sector
  input  logic                                 s_axis_tuser,  // [0] opcode
  // result item
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pmftl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [6:0] first_page,
                                                              // [13:7] second_page,
                                                              // [15:14] status
  output logic [pmftl_pkg::KIND_W-1:0]         m_axis_tuser,  // [1:0] kind
  output logic                                 m_axis_tlast   // last
);

  pmftl_pkg::dp_cmd_t  cmd;
  pmftl_pkg::dp_stat_t stat;
  pmftl_pkg::kind_t    out_kind;
  pmftl_pkg::status_t  out_status;
  logic [pmftl_pkg::FPAGE_W-1:0] out_first;
  logic [pmftl_pkg::FPAGE_W-1:0] out_second;

  // fsm: lookup, free-page scan, greedy victim scan, copy/erase sequence
  pmftl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // map table, bitmaps, scan counters and the result register
  pmftl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_op      (s_axis_tuser),
    .in_lsn     (s_axis_tdata[pmftl_pkg::LSN_W-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (out_kind),
    .out_first  (out_first),
    .out_second (out_second),
    .out_status (out_status),
    .out_last   (m_axis_tlast)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = {out_status, out_second, out_first};
  assign m_axis_tuser = out_kind;

endmodule

// ===== hdl/pmftl_checker.sv =====
// port-level checks for the translation engine, bound to the top level
`timescale 1ns / 1ps
`include "page_map_ftl_with_gc_assert.svh"

module pmftl_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [pmftl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic [pmftl_pkg::KIND_W-1:0]        m_axis_tuser,
  input logic                                m_axis_tlast
);

  // a stalled result holds
  `PMFTL_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // the mapping result is the one and only last item
  `PMFTL_ASSERT_IMP(a_last_is_map, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == pmftl_pkg::KIND_MAP), "tlast does not match mapping result")

  // copy and erase commands always carry ok status
  `PMFTL_ASSERT_IMP(a_cmd_status, m_axis_tvalid && (m_axis_tuser != pmftl_pkg::KIND_MAP), m_axis_tdata[15:14] == pmftl_pkg::STAT_OK, "command item with nonzero status")

  // no new item while collection items are still pending
  `PMFTL_ASSERT_IMP(a_no_accept_mid, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready during collection")

  // one item in flight at a time
  `PMFTL_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

endmodule

bind page_map_ftl_with_gc pmftl_checker u_pmftl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
